// ===== hdl/spp_pkg.sv =====
// Package for the stepper preset positioner: motion modes, result record,
// homing configuration record, register indexes, reset values and coil table.
// No dependencies.
package spp_pkg;

    // Widths of the fixed fields.
    localparam int POS_W      = 8;
    localparam int COIL_W     = 4;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int MAX_PRESETS = 6;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GOTO = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HOME = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd3;

    // Register indexes for the homing counts.
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_OVERSHOOT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_BACKOFF   = 3'd7;

    // Register values after reset.
    localparam logic [POS_W-1:0] PRESET_RST [MAX_PRESETS] = '{
        8'd195, 8'd28, 8'd62, 8'd96, 8'd129, 8'd162
    };
    localparam logic [POS_W-1:0] HOME_OVERSHOOT_RST = 8'd200;
    localparam logic [POS_W-1:0] HOME_BACKOFF_RST   = 8'd5;

    // One-hot coil codes: bit0 green, bit1 yellow, bit2 black, bit3 white.
    localparam logic [COIL_W-1:0] COIL_GREEN  = 4'b0001;
    localparam logic [COIL_W-1:0] COIL_YELLOW = 4'b0010;
    localparam logic [COIL_W-1:0] COIL_BLACK  = 4'b0100;
    localparam logic [COIL_W-1:0] COIL_WHITE  = 4'b1000;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_GOTO     = 2'd1,
        MODE_HOME_CW  = 2'd2,
        MODE_HOME_CCW = 2'd3
    } t_mode;

    typedef struct packed {
        logic [POS_W-1:0] overshoot;
        logic [POS_W-1:0] backoff;
    } t_home_cfg;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic [POS_W-1:0]  cur_position;
        logic              busy_res;
        logic              stepped;
        logic              rejected;
    } t_result;

    // Wave drive: phase 0 black, 1 yellow, 2 white, 3 green.
    function automatic logic [COIL_W-1:0] coil_of_phase(input logic [1:0] phase);
        logic [COIL_W-1:0] coil;
        case (phase)
            2'd0:    coil = COIL_BLACK;
            2'd1:    coil = COIL_YELLOW;
            2'd2:    coil = COIL_WHITE;
            default: coil = COIL_GREEN;
        endcase
        return coil;
    endfunction

endpackage

// ===== hdl/spp_core.sv =====
// Motion state and single-pass request processing for the stepper positioner.
// Depends on spp_pkg.
module spp_core import spp_pkg::*; #(
    parameter int NUM_PRESETS = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [FUNC_W-1:0]                i_func,
    input  logic [POS_W-1:0]                 i_value,
    input  logic [NUM_PRESETS-1:0][POS_W-1:0] i_presets,
    input  t_home_cfg                        i_home,
    output t_result                          o_result
);

    localparam int PIDX_W = (NUM_PRESETS > 1) ? $clog2(NUM_PRESETS) : 1;

    t_mode            r_mode,  n_mode;
    logic [1:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [COIL_W-1:0] r_coil, n_coil;
    logic [POS_W-1:0] r_steps, n_steps;
    logic             r_cw,    n_cw;

    logic [POS_W-1:0] steps_dec;
    logic [POS_W-1:0] target;
    logic [POS_W-1:0] home_pos;
    logic             step_cw;
    logic             stepped;
    logic             rejected;

    // State registers; they move only when a request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_phase <= 2'd0;
            r_pos   <= '0;
            r_coil  <= '0;
            r_steps <= '0;
            r_cw    <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_coil  <= n_coil;
            r_steps <= n_steps;
            r_cw    <= n_cw;
        end
    end

    assign steps_dec = r_steps - 8'd1;
    assign target    = i_presets[i_value[PIDX_W-1:0]];
    assign home_pos  = i_home.overshoot - i_home.backoff;
    assign step_cw   = (r_mode == MODE_GOTO) ? r_cw : (r_mode == MODE_HOME_CW);

    // Next state for the request at the input.
    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_coil   = r_coil;
        n_steps  = r_steps;
        n_cw     = r_cw;
        stepped  = 1'b0;
        rejected = 1'b0;

        if (i_func == FUNC_TICK) begin
            if (r_mode != MODE_IDLE) begin
                // One step in the current direction, then check leg end.
                stepped = 1'b1;
                n_phase = step_cw ? r_phase + 2'd1 : r_phase - 2'd1;
                n_pos   = step_cw ? r_pos + 8'd1 : r_pos - 8'd1;
                n_coil  = coil_of_phase(n_phase);
                n_steps = steps_dec;
                if (steps_dec == '0) begin
                    case (r_mode)
                        MODE_GOTO: begin
                            n_mode = MODE_IDLE;
                        end
                        MODE_HOME_CW: begin
                            if (i_home.backoff != '0) begin
                                n_mode  = MODE_HOME_CCW;
                                n_steps = i_home.backoff;
                            end else begin
                                n_mode = MODE_IDLE;
                                n_pos  = home_pos;
                            end
                        end
                        default: begin
                            n_mode = MODE_IDLE;
                            n_pos  = home_pos;
                        end
                    endcase
                end
            end
        end else if (r_mode != MODE_IDLE) begin
            rejected = 1'b1;
        end else begin
            case (i_func)
                FUNC_GOTO: begin
                    if (i_value >= POS_W'(NUM_PRESETS)) begin
                        rejected = 1'b1;
                    end else begin
                        n_cw    = target > r_pos;
                        n_steps = (target > r_pos) ? target - r_pos : r_pos - target;
                        n_mode  = (n_steps != '0) ? MODE_GOTO : MODE_IDLE;
                    end
                end
                FUNC_HOME: begin
                    // Skip any homing leg of zero steps.
                    if (i_home.overshoot != '0) begin
                        n_mode  = MODE_HOME_CW;
                        n_steps = i_home.overshoot;
                    end else if (i_home.backoff != '0) begin
                        n_mode  = MODE_HOME_CCW;
                        n_steps = i_home.backoff;
                    end else begin
                        n_pos   = home_pos;
                        n_steps = '0;
                    end
                end
                default: begin
                    n_pos = i_value;
                end
            endcase
        end

        o_result.coils        = n_coil;
        o_result.cur_position = n_pos;
        o_result.busy_res     = (n_mode != MODE_IDLE);
        o_result.stepped      = stepped;
        o_result.rejected     = rejected;
    end

endmodule

// ===== hdl/spp_out_buf.sv =====
// Two-entry result buffer: an output register plus a skid entry, so that a
// new request is taken while a finished result still waits. Depends on spp_pkg.
module spp_out_buf import spp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_valid, n_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_data, n_data;
    t_result r_skid, n_skid;
    logic    take;

    assign take    = r_valid && !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_full  = r_skid_valid;

    // Control bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_skid <= n_skid;
    end

    // Fill the output register first; park in the skid entry when it is held.
    always_comb begin
        n_valid      = r_valid;
        n_skid_valid = r_skid_valid;
        n_data       = r_data;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_data       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_load) begin
            if (!r_valid || take) begin
                n_data  = i_data;
                n_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_valid = 1'b0;
        end
    end

endmodule

// ===== hdl/stepper_preset_positioner.sv =====
// Top level of the four-phase wave-drive stepper positioner: configuration
// registers and the instances of spp_core and spp_out_buf. Depends on spp_pkg.
//
// One request (tick, goto preset, home or set position) is taken every clock
// cycle while o_in_stall is low, and its result is registered into the result
// buffer for the output channel. The motion state and the result are computed
// in a single pass of logic from the state registers and the request, and a
// two-entry result buffer lets the block keep taking requests while one result
// is held by o_out_valid with i_out_stall high; o_in_stall rises only when
// both entries are occupied. Configuration writes take effect at the next
// edge and should be made while no request is in flight.
module stepper_preset_positioner import spp_pkg::*; #(
    parameter int NUM_PRESETS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [POS_W-1:0]      i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COIL_W-1:0]     o_coils,
    output logic [POS_W-1:0]      o_cur_position,
    output logic                  o_busy_res,
    output logic                  o_stepped,
    output logic                  o_rejected
);

    logic [NUM_PRESETS-1:0][POS_W-1:0] r_presets;
    t_home_cfg r_home;
    t_result   core_result;
    t_result   out_result;
    logic      buf_full;
    logic      accept;

    assign accept     = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    // Preset target registers.
    for (genvar g = 0; g < NUM_PRESETS; g++) begin : g_preset
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_presets[g] <= PRESET_RST[g];
            end else if (i_cfg_we && i_cfg_index == CFG_IDX_W'(g)) begin
                r_presets[g] <= i_cfg_data;
            end
        end
    end

    // Homing counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home.overshoot <= HOME_OVERSHOOT_RST;
            r_home.backoff   <= HOME_BACKOFF_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_HOME_OVERSHOOT) begin
                r_home.overshoot <= i_cfg_data;
            end
            if (i_cfg_index == CFG_HOME_BACKOFF) begin
                r_home.backoff <= i_cfg_data;
            end
        end
    end

    spp_core #(
        .NUM_PRESETS (NUM_PRESETS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_func    (i_func),
        .i_value   (i_value),
        .i_presets (r_presets),
        .i_home    (r_home),
        .o_result  (core_result)
    );

    spp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_data  (core_result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_result)
    );

    assign o_coils        = out_result.coils;
    assign o_cur_position = out_result.cur_position;
    assign o_busy_res     = out_result.busy_res;
    assign o_stepped      = out_result.stepped;
    assign o_rejected     = out_result.rejected;

endmodule
